// ----- hw/rtl/rsz_pkg.sv -----
package rsz_pkg;

  // Default store geometry
  localparam int unsigned MAX_WIDTH_DEF    = 256;
  localparam int unsigned MAX_HEIGHT_DEF   = 256;
  localparam int unsigned MAX_CHANNELS_DEF = 4;

  // Register widths
  localparam int unsigned SRC_SIZE_W = 9;
  localparam int unsigned DST_SIZE_W = 13;
  localparam int unsigned SCALE_W    = 25;
  localparam int unsigned CHCNT_W    = 3;

  // Item field widths
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned CH_W     = 2;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  // Fixed point
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned POS_W  = COORD_W + SCALE_W;
  localparam int unsigned INT_W  = POS_W - FRAC_W;
  localparam int unsigned WGT_W  = 2 * FRAC_W + 1;
  localparam int unsigned PROD_W = WGT_W + SAMPLE_W;
  localparam int unsigned ACC_W  = PROD_W + 2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_DST_WIDTH  = 3'd2,
    CFG_DST_HEIGHT = 3'd3,
    CFG_SCALE_X    = 3'd4,
    CFG_SCALE_Y    = 3'd5,
    CFG_CH_COUNT   = 3'd6
  } cfg_idx_e;

  // Action codes
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

endpackage

// ----- hw/rtl/bilinear_image_resize_top.sv -----
// Bilinear image scaler with a built-in source image store. An input item with
// tuser 0 loads one 8-bit source sample at (column, row, channel); an item with
// tuser 1 requests one destination pixel and yields exactly one result item,
// status 1 and pixel 0 when the coordinate or channel is out of range. The
// store is split into four banks by column and row parity, so the four
// neighbors are read in the same cycle; its contents are undefined until
// loaded. The block is a five-stage pipeline (position multiply, clamp and
// address, bank read with weight multiply, sample multiply, sum and saturate)
// and takes one item per cycle while the output is not stalled; a request's
// result is offered from the sum and saturate stage. The user must write
// configuration through the cfg port only while the block is idle; the block
// itself does not enforce this, and cfg_ready_o is always high.
module bilinear_image_resize_top #(
  parameter int unsigned MAX_WIDTH    = rsz_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT   = rsz_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned MAX_CHANNELS = rsz_pkg::MAX_CHANNELS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rsz_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rsz_pkg::SCALE_W-1:0]       cfg_data_i,
  // input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // column[11:0], row[23:12], channel[25:24], sample[33:26], zero pad
  input  logic [rsz_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // action[0]
  input  logic                              s_axis_tuser,
  // result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pixel[7:0], out_column[19:8], out_row[31:20], out_channel[33:32], zero pad
  output logic [rsz_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // status[0]
  output logic                              m_axis_tuser
);
  import rsz_pkg::*;

  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned SWW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SHW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned HALF_W = (MAX_WIDTH + 1) / 2;
  localparam int unsigned HALF_H = (MAX_HEIGHT + 1) / 2;
  localparam int unsigned BANK_DEPTH = HALF_W * HALF_H * MAX_CHANNELS;
  localparam int unsigned AW    = $clog2(BANK_DEPTH);

  // ---------------- configuration registers ----------------
  logic [SRC_SIZE_W-1:0] src_width_q, src_height_q;
  logic [DST_SIZE_W-1:0] dst_width_q, dst_height_q;
  logic [SCALE_W-1:0]    scale_x_q, scale_y_q;
  logic [CHCNT_W-1:0]    ch_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= SRC_SIZE_W'(256);
      src_height_q <= SRC_SIZE_W'(256);
      dst_width_q  <= DST_SIZE_W'(256);
      dst_height_q <= DST_SIZE_W'(256);
      scale_x_q    <= SCALE_W'(65536);
      scale_y_q    <= SCALE_W'(65536);
      ch_count_q   <= CHCNT_W'(3);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SRC_WIDTH:  src_width_q  <= cfg_data_i[SRC_SIZE_W-1:0];
        CFG_SRC_HEIGHT: src_height_q <= cfg_data_i[SRC_SIZE_W-1:0];
        CFG_DST_WIDTH:  dst_width_q  <= cfg_data_i[DST_SIZE_W-1:0];
        CFG_DST_HEIGHT: dst_height_q <= cfg_data_i[DST_SIZE_W-1:0];
        CFG_SCALE_X:    scale_x_q    <= cfg_data_i;
        CFG_SCALE_Y:    scale_y_q    <= cfg_data_i;
        CFG_CH_COUNT:   ch_count_q   <= cfg_data_i[CHCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective source size: zero reads as one, capped at the store size
  logic [SWW-1:0] sw_eff;
  logic [SHW-1:0] sh_eff;
  always_comb begin
    if (src_width_q == '0) sw_eff = SWW'(1);
    else if (32'(src_width_q) > MAX_WIDTH) sw_eff = SWW'(MAX_WIDTH);
    else sw_eff = SWW'(src_width_q);
    if (src_height_q == '0) sh_eff = SHW'(1);
    else if (32'(src_height_q) > MAX_HEIGHT) sh_eff = SHW'(MAX_HEIGHT);
    else sh_eff = SHW'(src_height_q);
  end

  // ---------------- stall chain ----------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;
  logic act2_q;
  assign en5 = !v5_q || m_axis_tready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q && (act2_q == ACT_REQUEST);
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // ---------------- stage 1: position multiply, range check ----------------
  logic [COORD_W-1:0]  in_col, in_row;
  logic [CH_W-1:0]     in_ch;
  logic [SAMPLE_W-1:0] in_smp;
  assign in_col = s_axis_tdata[COORD_W-1:0];
  assign in_row = s_axis_tdata[2*COORD_W-1:COORD_W];
  assign in_ch  = s_axis_tdata[2*COORD_W+CH_W-1:2*COORD_W];
  assign in_smp = s_axis_tdata[2*COORD_W+CH_W+SAMPLE_W-1:2*COORD_W+CH_W];

  logic                act1_q, err1_q;
  logic [COORD_W-1:0]  col1_q, row1_q;
  logic [CH_W-1:0]     ch1_q;
  logic [SAMPLE_W-1:0] smp1_q;
  logic [POS_W-1:0]    fx1_q, fy1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      act1_q <= s_axis_tuser;
      col1_q <= in_col;
      row1_q <= in_row;
      ch1_q  <= in_ch;
      smp1_q <= in_smp;
      err1_q <= ({1'b0, in_col} >= dst_width_q) || ({1'b0, in_row} >= dst_height_q) ||
                ({1'b0, in_ch} >= ch_count_q) || (32'(in_ch) >= MAX_CHANNELS);
      fx1_q  <= POS_W'(in_col) * POS_W'(scale_x_q);
      fy1_q  <= POS_W'(in_row) * POS_W'(scale_y_q);
    end
  end

  // ---------------- stage 2: clamp, bank addresses ----------------
  logic [INT_W-1:0]  ix, iy;
  logic [INT_W:0]    ix1, iy1;
  logic [XW-1:0]     x0, x1;
  logic [YW-1:0]     y0, y1;
  logic [AW-1:0]     rd_addr [4];
  logic [AW-1:0]     wr_addr;
  logic              wr_inb;

  assign ix  = fx1_q[POS_W-1:FRAC_W];
  assign iy  = fy1_q[POS_W-1:FRAC_W];
  assign ix1 = {1'b0, ix} + 1'b1;
  assign iy1 = {1'b0, iy} + 1'b1;

  always_comb begin
    x0 = (ix  >= INT_W'(sw_eff))     ? XW'(sw_eff - 1'b1) : XW'(ix);
    x1 = (ix1 >= (INT_W+1)'(sw_eff)) ? XW'(sw_eff - 1'b1) : XW'(ix1);
    y0 = (iy  >= INT_W'(sh_eff))     ? YW'(sh_eff - 1'b1) : YW'(iy);
    y1 = (iy1 >= (INT_W+1)'(sh_eff)) ? YW'(sh_eff - 1'b1) : YW'(iy1);
  end

  // each bank holds one column parity and one row parity
  for (genvar b = 0; b < 4; b++) begin : g_addr
    logic [XW-1:0] xs;
    logic [YW-1:0] ys;
    assign xs = (x0[0] == 1'(b)) ? x0 : x1;
    assign ys = (y0[0] == 1'(b >> 1)) ? y0 : y1;
    assign rd_addr[b] = AW'(((32'(ys >> 1) * HALF_W + 32'(xs >> 1)) * MAX_CHANNELS) +
                            32'(ch1_q));
  end

  assign wr_inb  = (32'(col1_q) < MAX_WIDTH) && (32'(row1_q) < MAX_HEIGHT) &&
                   (32'(ch1_q) < MAX_CHANNELS);
  assign wr_addr = AW'(((32'(row1_q >> 1) * HALF_W + 32'(col1_q >> 1)) * MAX_CHANNELS) +
                       32'(ch1_q));

  logic                err2_q, wr_en2_q;
  logic [1:0]          wr_bank2_q;
  logic [AW-1:0]       wr_addr2_q;
  logic [AW-1:0]       rd_addr2_q [4];
  logic [SAMPLE_W-1:0] smp2_q;
  logic [COORD_W-1:0]  col2_q, row2_q;
  logic [CH_W-1:0]     ch2_q;
  logic [FRAC_W-1:0]   dx2_q, dy2_q;
  logic                x0p2_q, x1p2_q, y0p2_q, y1p2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      act2_q     <= act1_q;
      err2_q     <= err1_q;
      wr_en2_q   <= wr_inb;
      wr_bank2_q <= {row1_q[0], col1_q[0]};
      wr_addr2_q <= wr_addr;
      rd_addr2_q <= rd_addr;
      smp2_q     <= smp1_q;
      col2_q     <= col1_q;
      row2_q     <= row1_q;
      ch2_q      <= ch1_q;
      dx2_q      <= fx1_q[FRAC_W-1:0];
      dy2_q      <= fy1_q[FRAC_W-1:0];
      x0p2_q     <= x0[0];
      x1p2_q     <= x1[0];
      y0p2_q     <= y0[0];
      y1p2_q     <= y1[0];
    end
  end

  // ---------------- stage 3: bank access, weight products ----------------
  logic [SAMPLE_W-1:0] rd3 [4];
  logic                do_wr, do_rd;
  assign do_wr = en3 && v2_q && (act2_q == ACT_LOAD) && wr_en2_q;
  assign do_rd = en3 && v2_q && (act2_q == ACT_REQUEST);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [SAMPLE_W-1:0] mem [BANK_DEPTH];
    logic [SAMPLE_W-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (do_wr && (wr_bank2_q == 2'(b))) begin
        mem[wr_addr2_q] <= smp2_q;
      end
      if (do_rd) begin
        rd_q <= mem[rd_addr2_q[b]];
      end
    end
    assign rd3[b] = rd_q;
  end

  logic [FRAC_W:0]     wx0, wy0;
  logic [WGT_W-1:0]    w00_3_q, w10_3_q, w01_3_q, w11_3_q;
  logic                err3_q, x0p3_q, x1p3_q, y0p3_q, y1p3_q;
  logic [COORD_W-1:0]  col3_q, row3_q;
  logic [CH_W-1:0]     ch3_q;

  assign wx0 = (FRAC_W+1)'(1 << FRAC_W) - (FRAC_W+1)'(dx2_q);
  assign wy0 = (FRAC_W+1)'(1 << FRAC_W) - (FRAC_W+1)'(dy2_q);

  always_ff @(posedge clk_i) begin
    if (en3) begin
      w00_3_q <= WGT_W'(wy0) * WGT_W'(wx0);
      w10_3_q <= WGT_W'(wy0) * WGT_W'(dx2_q);
      w01_3_q <= WGT_W'(dy2_q) * WGT_W'(wx0);
      w11_3_q <= WGT_W'(dy2_q) * WGT_W'(dx2_q);
      err3_q  <= err2_q;
      col3_q  <= col2_q;
      row3_q  <= row2_q;
      ch3_q   <= ch2_q;
      x0p3_q  <= x0p2_q;
      x1p3_q  <= x1p2_q;
      y0p3_q  <= y0p2_q;
      y1p3_q  <= y1p2_q;
    end
  end

  // ---------------- stage 4: weighted samples ----------------
  logic [SAMPLE_W-1:0] s00, s10, s01, s11;
  assign s00 = rd3[{y0p3_q, x0p3_q}];
  assign s10 = rd3[{y0p3_q, x1p3_q}];
  assign s01 = rd3[{y1p3_q, x0p3_q}];
  assign s11 = rd3[{y1p3_q, x1p3_q}];

  logic [PROD_W-1:0]   p00_4_q, p10_4_q, p01_4_q, p11_4_q;
  logic                err4_q;
  logic [COORD_W-1:0]  col4_q, row4_q;
  logic [CH_W-1:0]     ch4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      p00_4_q <= PROD_W'(s00) * PROD_W'(w00_3_q);
      p10_4_q <= PROD_W'(s10) * PROD_W'(w10_3_q);
      p01_4_q <= PROD_W'(s01) * PROD_W'(w01_3_q);
      p11_4_q <= PROD_W'(s11) * PROD_W'(w11_3_q);
      err4_q  <= err3_q;
      col4_q  <= col3_q;
      row4_q  <= row3_q;
      ch4_q   <= ch3_q;
    end
  end

  // ---------------- stage 5: sum, truncate, saturate ----------------
  logic [ACC_W-1:0]          acc;
  logic [ACC_W-2*FRAC_W-1:0] acc_hi;
  logic [SAMPLE_W-1:0]       pix;
  assign acc = ACC_W'(p00_4_q) + ACC_W'(p10_4_q) + ACC_W'(p01_4_q) + ACC_W'(p11_4_q);
  assign acc_hi = acc[ACC_W-1:2*FRAC_W];
  always_comb begin
    if (err4_q) pix = '0;
    else if (acc_hi > (ACC_W-2*FRAC_W)'(255)) pix = '1;
    else pix = SAMPLE_W'(acc_hi);
  end

  logic [SAMPLE_W-1:0] pix5_q;
  logic                err5_q;
  logic [COORD_W-1:0]  col5_q, row5_q;
  logic [CH_W-1:0]     ch5_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      pix5_q <= pix;
      err5_q <= err4_q;
      col5_q <= col4_q;
      row5_q <= row4_q;
      ch5_q  <= ch4_q;
    end
  end

  assign m_axis_tvalid = v5_q;
  assign m_axis_tuser  = err5_q;
  assign m_axis_tdata  = {(OUT_DATA_W - SAMPLE_W - 2*COORD_W - CH_W)'(0),
                          ch5_q, row5_q, col5_q, pix5_q};

endmodule

// ----- bench/resize_checker.sv -----
`timescale 1ns / 1ps

module resize_checker
  import rsz_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [SCALE_W-1:0]     cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [IN_DATA_W-1:0]   in_data_i,
  input  logic                   in_user_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [OUT_DATA_W-1:0]  out_data_i,
  input  logic                   out_user_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [7:0]  pixel;
    logic [11:0] col;
    logic [11:0] row;
    logic [1:0]  ch;
    logic        status;
  } pixel_res_t;

  logic [7:0]  src_store [int];
  logic [8:0]  src_w, src_h;
  logic [12:0] dst_w, dst_h;
  logic [24:0] scl_x, scl_y;
  logic [2:0]  ch_cnt;
  pixel_res_t  expected_q[$];

  assign pending_o = expected_q.size();

  function automatic logic [63:0] sample_at(int x, int y, int c);
    int idx;
    idx = (y * 256 + x) * 4 + c;
    return src_store.exists(idx) ? 64'(src_store[idx]) : 64'd0;
  endfunction

  function automatic int fit_size(int v);
    if (v == 0) return 1;
    return (v > 256) ? 256 : v;
  endfunction

  function automatic int edge_clamp(logic [63:0] v, int sz);
    return (v >= 64'(sz)) ? sz - 1 : int'(v);
  endfunction

  // Interpolate one destination pixel
  function automatic pixel_res_t interpolate(logic [11:0] col, logic [11:0] row,
                                             logic [1:0] ch);
    pixel_res_t r;
    int sw, sh, x0, x1, y0, y1;
    logic [63:0] fx, fy, dx, dy, wx0, wy0, acc, res;
    r.col = col; r.row = row; r.ch = ch;
    if (col >= dst_w || row >= dst_h || ch >= ch_cnt) begin
      r.pixel = 0; r.status = 1'b1;
      return r;
    end
    sw = fit_size(src_w); sh = fit_size(src_h);
    fx = 64'(col) * 64'(scl_x);
    fy = 64'(row) * 64'(scl_y);
    dx = fx & 64'hFFFF; dy = fy & 64'hFFFF;
    x0 = edge_clamp(fx >> 16, sw); x1 = edge_clamp((fx >> 16) + 1, sw);
    y0 = edge_clamp(fy >> 16, sh); y1 = edge_clamp((fy >> 16) + 1, sh);
    wx0 = 65536 - dx; wy0 = 65536 - dy;
    acc = sample_at(x0, y0, ch) * (wy0 * wx0) + sample_at(x1, y0, ch) * (wy0 * dx)
        + sample_at(x0, y1, ch) * (dy * wx0) + sample_at(x1, y1, ch) * (dy * dx);
    res = acc >> 32;
    r.pixel = (res > 255) ? 8'd255 : res[7:0];
    r.status = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_res_t got, exp_r;
    logic [11:0] c, r;
    logic [1:0] ch;
    if (!rst_ni) begin
      src_w <= 256; src_h <= 256; dst_w <= 256; dst_h <= 256;
      scl_x <= 65536; scl_y <= 65536; ch_cnt <= 3;
      fail_count_o <= 0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SRC_WIDTH:  src_w  <= cfg_data_i[8:0];
          CFG_SRC_HEIGHT: src_h  <= cfg_data_i[8:0];
          CFG_DST_WIDTH:  dst_w  <= cfg_data_i[12:0];
          CFG_DST_HEIGHT: dst_h  <= cfg_data_i[12:0];
          CFG_SCALE_X:    scl_x  <= cfg_data_i;
          CFG_SCALE_Y:    scl_y  <= cfg_data_i;
          CFG_CH_COUNT:   ch_cnt <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      // accepted input item
      if (in_valid_i && in_ready_i) begin
        c = in_data_i[11:0]; r = in_data_i[23:12]; ch = in_data_i[25:24];
        if (in_user_i == ACT_LOAD) begin
          if (c < 256 && r < 256)
            src_store[(int'(r) * 256 + int'(c)) * 4 + int'(ch)] = in_data_i[33:26];
        end else
          expected_q.push_back(interpolate(c, r, ch));
      end
      // accepted result item
      if (out_valid_i && out_ready_i) begin
        got = {out_data_i[7:0], out_data_i[19:8], out_data_i[31:20],
               out_data_i[33:32], out_user_i};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected pix=%0d col=%0d row=%0d ch=%0d st=%0d",
                     $time, exp_r.pixel, exp_r.col, exp_r.row, exp_r.ch, exp_r.status);
            $display("%0t:          actual   pix=%0d col=%0d row=%0d ch=%0d st=%0d",
                     $time, got.pixel, got.col, got.row, got.ch, got.status);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import rsz_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [SCALE_W-1:0]    cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [IN_DATA_W-1:0]  in_data = '0;
  logic                  in_user = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_DATA_W-1:0] out_data;
  logic                  out_user;
  int                    fail_count, pending;
  int                    send_idle_pct = 0, recv_idle_pct = 0;
  int                    idle_cycles = 0;
  bit                    hold_off = 1'b0;

  always #1 clk_i = ~clk_i;

  bilinear_image_resize_top dut (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .s_axis_tvalid(in_valid), .s_axis_tready(in_ready),
    .s_axis_tdata(in_data), .s_axis_tuser(in_user),
    .m_axis_tvalid(out_valid), .m_axis_tready(out_ready),
    .m_axis_tdata(out_data), .m_axis_tuser(out_user)
  );

  resize_checker chk (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .in_data_i(in_data), .in_user_i(in_user),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .out_data_i(out_data), .out_user_i(out_user),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver backpressure
  always @(posedge clk_i) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on accepted items
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // valid stays up after acceptance; the next item or an idle cycle replaces it
  task automatic send_item(logic act, logic [11:0] col, logic [11:0] row,
                           logic [1:0] ch, logic [7:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_user  <= act;
    in_data  <= {6'd0, smp, ch, row, col};
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [SCALE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic set_geometry(int sw, int sh, int dw, int dh, int sx, int sy, int cc);
    drain();
    write_reg(CFG_SRC_WIDTH, SCALE_W'(sw));
    write_reg(CFG_SRC_HEIGHT, SCALE_W'(sh));
    write_reg(CFG_DST_WIDTH, SCALE_W'(dw));
    write_reg(CFG_DST_HEIGHT, SCALE_W'(dh));
    write_reg(CFG_SCALE_X, SCALE_W'(sx));
    write_reg(CFG_SCALE_Y, SCALE_W'(sy));
    write_reg(CFG_CH_COUNT, SCALE_W'(cc));
    cfg_valid <= 1'b0;
  endtask

  // Request whose neighbors stay within the loaded window; errors pass freely
  task automatic random_request(int dw, int dh);
    logic [11:0] c, r;
    if ($urandom_range(9) == 0) c = 12'($urandom_range(4095));
    else c = 12'($urandom_range(dw > 0 ? dw - 1 : 0));
    if ($urandom_range(9) == 0) r = 12'($urandom_range(4095));
    else r = 12'($urandom_range(dh > 0 ? dh - 1 : 0));
    send_item(ACT_REQUEST, c, r, 2'($urandom_range(3)), 8'($urandom));
  endtask

  task automatic load_block(int w, int h);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        for (int c = 0; c < 4; c++)
          send_item(ACT_LOAD, 12'(x), 12'(y), 2'(c), 8'($urandom));
  endtask

  initial begin
    int sw, sh, dw, dh;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: small source fully loaded, extremes of sample and coordinates
    set_geometry(4, 4, 8, 8, 32768, 32768, 4);
    for (int y = 0; y < 4; y++)
      for (int x = 0; x < 4; x++)
        for (int c = 0; c < 4; c++)
          send_item(ACT_LOAD, 12'(x), 12'(y), 2'(c), ((x + y + c) & 1) ? 8'hFF : 8'h00);
    send_item(ACT_LOAD, 12'hFFF, 12'hFFF, 2'd3, 8'hAA);    // outside store, ignored
    send_item(ACT_LOAD, 12'd256, 12'd0, 2'd0, 8'h55);      // outside store, ignored
    send_item(ACT_REQUEST, 12'd0, 12'd0, 2'd0, 8'hFF);
    send_item(ACT_REQUEST, 12'd7, 12'd7, 2'd3, 8'h00);     // right and bottom edge clamp
    send_item(ACT_REQUEST, 12'd3, 12'd5, 2'd1, 8'h12);
    send_item(ACT_REQUEST, 12'd8, 12'd0, 2'd0, 8'd0);      // column out of range
    send_item(ACT_REQUEST, 12'd0, 12'd8, 2'd0, 8'd0);      // row out of range
    send_item(ACT_REQUEST, 12'hFFF, 12'hFFF, 2'd3, 8'd0);
    // large scale, zero source size, channel count limit
    set_geometry(0, 300, 4096, 4096, 16777216, 16777216, 1);
    send_item(ACT_REQUEST, 12'hFFF, 12'd0, 2'd0, 8'd0);    // column clamps to the edge
    send_item(ACT_REQUEST, 12'd1, 12'd2, 2'd1, 8'd0);      // channel beyond count
    set_geometry(4, 4, 0, 0, 0, 0, 0);                      // zero registers flag all
    send_item(ACT_REQUEST, 12'd0, 12'd0, 2'd0, 8'd0);
    set_geometry(4, 4, 4, 4, 65535, 65535, 7);
    send_item(ACT_REQUEST, 12'd3, 12'd3, 2'd3, 8'd0);

    // Random phases over several geometries and idle mixes
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 77 : 0;
      recv_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 30 : 0;
      sw = $urandom_range(2, 8); sh = $urandom_range(1, 6);
      if (ph == 2) begin sw = 1; sh = 2; end
      dw = $urandom_range(1, 24); dh = $urandom_range(1, 24);
      set_geometry(sw, sh, dw, dh, $urandom_range(1 << 18), $urandom_range(1 << 18),
                   $urandom_range(1, 4));
      load_block(sw, sh);
      for (int i = 0; i < 130; i++) random_request(dw, dh);
      // long receiver hold-off with the sender still offering items
      if (ph == 1) begin
        hold_off = 1'b1;
        fork
          begin repeat (300) @(posedge clk_i); hold_off = 1'b0; end
          for (int i = 0; i < 40; i++) random_request(dw, dh);
        join
      end
      drain();    // sender pauses until all results arrive
    end

    drain();
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
